[sv/bta_pkg.sv]
// Shared types, constants and helpers for the boundary-tag heap allocator.
// No dependencies; imported by the core, bta_ctrl and bta_dp.
package bta_pkg;

    localparam int HEAP_WORDS_DEF = 4096;
    localparam int OP_W           = 2;
    localparam int ADDR_W         = 14;
    localparam int REQ_W          = 16;
    localparam int CFG_W          = 15;
    localparam int TAG_W          = 32;

    localparam int RESET_CHUNK    = 1920;
    localparam int RESET_THRESH   = 128;
    localparam int FIRST_PAYLOAD  = 16;
    localparam int RESET_HEAP_END = FIRST_PAYLOAD + RESET_CHUNK;
    localparam int PROLOGUE_TAG   = 9;
    localparam int EPILOGUE_TAG   = 1;
    localparam int MIN_BLOCK      = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_CHUNK  = 1'b0,
        CFG_THRESH = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_CLEAR, CMD_LATCH,
        CMD_SR_INIT, CMD_SR_RD, CMD_SR_STEP, CMD_SR_HRD, CMD_SR_HDR,
        CMD_PL_SETUP, CMD_WR_HDR, CMD_WR_FTR, CMD_PL_ADV, CMD_PL_DONE,
        CMD_GR_SETUP, CMD_WR_EPI,
        CMD_MG_PRD, CMD_MG_NRD, CMD_MG_CALC,
        CMD_FR_SETUP,
        CMD_LV_CHK, CMD_LV_HDR,
        CMD_RA_NRD, CMD_RA_TAIL, CMD_RA_SETUP,
        CMD_FIN_OK, CMD_FIN_FAIL
    } t_cmd;

    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH,
        ST_SR_INIT, ST_SR_RD, ST_SR_STEP, ST_SR_HRD, ST_SR_HDR,
        ST_GR_SETUP, ST_GR_HDR, ST_GR_FTR, ST_GR_EPI,
        ST_MG_PRD, ST_MG_NRD, ST_MG_CALC, ST_MG_HDR, ST_MG_FTR,
        ST_PL_SETUP, ST_PL_HDR1, ST_PL_FTR1, ST_PL_ADV, ST_PL_HDR2, ST_PL_FTR2,
        ST_PL_DONE,
        ST_FR_SETUP, ST_FR_HDR, ST_FR_FTR,
        ST_LV_CHK, ST_LV_HDR, ST_LV_FTR,
        ST_RA_NRD, ST_RA_TAIL, ST_RA_SETUP, ST_RA_HDR, ST_RA_FTR, ST_RA_EPI,
        ST_FIN_OK, ST_FIN_FAIL
    } t_state;

    typedef enum logic [0:0] {
        RET_PLACE = 1'b0,
        RET_FIN   = 1'b1
    } t_ret;

    typedef struct packed {
        t_op  op;
        logic p_zero;
        logic req_zero;
        logic moving;
        logic clr_last;
        logic srch_end;
        logic srch_skip;
        logic fit;
        logic split;
        logic grow_fail;
        logic mg_both;
        logic lv_bad0;
        logic lv_bad1;
        logic lv_ftr_ok;
        logic ra_tail;
        logic ra_fits;
        logic ra_room;
    } t_dp_status;

    // Heap image after reset, by byte address of the word.
    function automatic logic [TAG_W-1:0] init_tag(input logic [TAG_W-1:0] a);
        logic [TAG_W-1:0] v;
        v = '0;
        if (a == TAG_W'(FIRST_PAYLOAD - 12) || a == TAG_W'(FIRST_PAYLOAD - 8)) begin
            v = TAG_W'(PROLOGUE_TAG);
        end else if (a == TAG_W'(FIRST_PAYLOAD - 4) ||
                     a == TAG_W'(RESET_HEAP_END - 8)) begin
            v = TAG_W'(RESET_CHUNK);
        end else if (a == TAG_W'(RESET_HEAP_END - 4)) begin
            v = TAG_W'(EPILOGUE_TAG);
        end
        return v;
    endfunction

endpackage

[sv/boundary_tag_heap_allocator_core.sv]
// Top level of the boundary-tag heap allocator: controller plus datapath.
// Depends on bta_pkg, bta_ctrl, bta_dp (and bta_ram through bta_dp).
//
// Hardware heap allocator with boundary tags in a word memory. After reset
// the block runs a clearing pass that writes the initial heap image, one
// word a cycle; busy stays high meanwhile. An operation is taken when
// start is high and busy is low; one result then appears on o_ok /
// o_result_address / o_copy_bytes for exactly one cycle with o_valid high,
// and must be captured then - there is no back-pressure.
// The next operation may be started in the very cycle the result shows.
// Timing is set by the single-port tag memory, which does one read or one
// write per cycle: allocate walks the blocks back from the heap end, grows
// the heap when no free block fits, and places the block, splitting it when
// the rest is large enough; free writes the tags and coalesces the block;
// reallocate adds a liveness check in front of the above, and a moving
// reallocate also pays for the free of the old block.
// Configuration writes (chunk size, small-request threshold) take effect at
// once and must only be issued while the block is idle.
module boundary_tag_heap_allocator_core #(
    parameter int HEAP_WORDS = bta_pkg::HEAP_WORDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [bta_pkg::OP_W-1:0]   i_opcode,
    input  logic [bta_pkg::ADDR_W-1:0] i_block_address,
    input  logic [bta_pkg::REQ_W-1:0]  i_request_size,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [bta_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_valid,
    output logic                       o_ok,
    output logic [bta_pkg::ADDR_W-1:0] o_result_address,
    output logic [bta_pkg::ADDR_W-1:0] o_copy_bytes
);
    import bta_pkg::*;

    t_cmd       cmd;
    t_dp_status status;

    // sequencer: one command per cycle to the datapath
    bta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_status(status),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // tag memory, heap registers and result register
    bta_dp #(
        .HEAP_WORDS(HEAP_WORDS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_opcode        (i_opcode),
        .i_block_address (i_block_address),
        .i_request_size  (i_request_size),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_ok            (o_ok),
        .o_result_address(o_result_address),
        .o_copy_bytes    (o_copy_bytes)
    );

    // a result is only presented once the sequencer is back in idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted transfer makes the block busy in the following cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted operation did not start");

    // failure returns a null address and no copy length
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_result_address == '0 && o_copy_bytes == '0))
        else $error("failed result carries data");

    // a tag write only happens while an operation is in progress
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == CMD_WR_HDR || cmd == CMD_WR_FTR || cmd == CMD_WR_EPI) |-> busy)
        else $error("tag write outside an operation");
endmodule

[sv/bta_ram.sv]
// Generic single-port word RAM with registered read.
// No dependencies.
module bta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[sv/bta_dp.sv]
// Datapath: heap tag memory, work registers, configuration and result registers.
// Depends on bta_pkg and bta_ram; driven by bta_ctrl through a command code.
module bta_dp #(
    parameter int HEAP_WORDS = bta_pkg::HEAP_WORDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bta_pkg::t_cmd              i_cmd,
    output bta_pkg::t_dp_status        o_status,
    input  logic [bta_pkg::OP_W-1:0]   i_opcode,
    input  logic [bta_pkg::ADDR_W-1:0] i_block_address,
    input  logic [bta_pkg::REQ_W-1:0]  i_request_size,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [bta_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_valid,
    output logic                       o_ok,
    output logic [bta_pkg::ADDR_W-1:0] o_result_address,
    output logic [bta_pkg::ADDR_W-1:0] o_copy_bytes
);
    import bta_pkg::*;

    localparam int IW = $clog2(HEAP_WORDS);
    localparam int AW = IW + 2;
    localparam int W  = (AW + 1 > 18) ? AW + 1 : 18;
    localparam logic [W-1:0] HEAP_BYTES = W'(HEAP_WORDS * 4);

    typedef struct packed {
        t_op              op;
        logic [W-1:0]     p;
        logic [REQ_W-1:0] req;
        logic [W-1:0]     asize;
        logic [W-1:0]     cur;
        logic [W-1:0]     bp;
        logic [W-1:0]     size;
        logic [W-1:0]     csize;
        logic [W-1:0]     has;
        logic             alloc;
        logic             split;
        logic             moving;
        logic [TAG_W-1:0] t;
        logic [TAG_W-1:0] pt;
        logic [W-1:0]     res;
        logic [W-1:0]     copy;
    } t_work;

    t_work r_w, n_w;

    logic [W-1:0]      r_heap_end, n_heap_end;
    logic [W-1:0]      r_skip, n_skip;
    logic [CFG_W-1:0]  r_chunk, r_thresh;
    logic [IW-1:0]     r_clr;
    logic              r_rd_oob;
    logic              r_valid, n_valid;
    logic              r_ok, n_ok;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [ADDR_W-1:0] r_out_copy, n_out_copy;

    logic [W-1:0]     mem_baddr;
    logic             mem_we;
    logic [TAG_W-1:0] mem_wdata;
    logic [IW-1:0]    ram_addr;
    logic             ram_we;
    logic [TAG_W-1:0] ram_wdata;
    logic [TAG_W-1:0] ram_rdata;
    logic             in_range;

    logic [TAG_W-1:0] q;
    logic [W-1:0]     q_size;
    logic [W-1:0]     sr_bp;
    logic [W-1:0]     chunk_r;
    logic [W-1:0]     grow;
    logic [W-1:0]     psize;
    logic [W-1:0]     copy_calc;
    logic [W-1:0]     has_m8;
    logic [W-1:0]     tag_val;

    function automatic logic [W-1:0] adjust(input logic [REQ_W-1:0] req);
        logic [REQ_W:0] s;
        s = (REQ_W+1)'(req) + (REQ_W+1)'(15);
        if (req <= REQ_W'(8)) begin
            return W'(MIN_BLOCK);
        end
        return W'({s[REQ_W:3], 3'b000});
    endfunction

    bta_ram #(
        .WIDTH(TAG_W),
        .DEPTH(HEAP_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // reads past the memory give zero
    assign q      = r_rd_oob ? '0 : ram_rdata;
    assign q_size = {q[W-1:3], 3'b000};
    assign sr_bp  = r_w.cur - q_size;
    assign psize  = {r_w.pt[W-1:3], 3'b000};
    assign chunk_r = (W'(r_chunk) + W'(7)) & ~W'(7);
    assign grow   = (r_w.asize > chunk_r) ? r_w.asize : chunk_r;
    assign has_m8 = r_w.has - W'(8);
    assign copy_calc = (W'(r_w.req) < has_m8) ? W'(r_w.req) : has_m8;
    assign tag_val = r_w.size | W'(r_w.alloc);

    // memory address and write decode
    always_comb begin
        mem_baddr = '0;
        mem_we    = 1'b0;
        mem_wdata = TAG_W'(tag_val);
        unique case (i_cmd)
            CMD_SR_RD:  mem_baddr = r_w.cur - W'(8);
            CMD_SR_HRD: mem_baddr = r_w.bp - W'(4);
            CMD_WR_HDR: begin
                mem_baddr = r_w.bp - W'(4);
                mem_we    = 1'b1;
            end
            CMD_WR_FTR: begin
                mem_baddr = r_w.bp + r_w.size - W'(8);
                mem_we    = 1'b1;
            end
            CMD_WR_EPI: begin
                mem_baddr = r_w.bp + r_w.size - W'(4);
                mem_we    = 1'b1;
                mem_wdata = TAG_W'(EPILOGUE_TAG);
            end
            CMD_MG_PRD: mem_baddr = r_w.bp - W'(8);
            CMD_MG_NRD: mem_baddr = r_w.bp + r_w.size - W'(4);
            CMD_LV_CHK: mem_baddr = r_w.p - W'(4);
            CMD_LV_HDR: mem_baddr = r_w.p + q_size - W'(8);
            CMD_RA_NRD: mem_baddr = r_w.p + r_w.has - W'(4);
            default: mem_baddr = '0;
        endcase
    end

    assign in_range  = mem_baddr < HEAP_BYTES;
    assign ram_addr  = (i_cmd == CMD_CLEAR) ? r_clr : mem_baddr[IW+1:2];
    assign ram_we    = (i_cmd == CMD_CLEAR) || (mem_we && in_range);
    assign ram_wdata = (i_cmd == CMD_CLEAR) ? init_tag(TAG_W'({r_clr, 2'b00})) : mem_wdata;

    // work register updates
    always_comb begin
        n_w        = r_w;
        n_heap_end = r_heap_end;
        n_skip     = r_skip;
        n_valid    = 1'b0;
        n_ok       = r_ok;
        n_out_addr = r_out_addr;
        n_out_copy = r_out_copy;
        unique case (i_cmd)
            CMD_LATCH: begin
                n_w.op     = t_op'(i_opcode);
                n_w.p      = W'(i_block_address);
                n_w.req    = i_request_size;
                n_w.asize  = adjust(i_request_size);
                n_w.moving = 1'b0;
                n_w.res    = '0;
                n_w.copy   = '0;
            end
            CMD_SR_INIT: n_w.cur = r_heap_end;
            CMD_SR_STEP: begin
                if (o_status.srch_end) begin
                    n_skip = '0;
                end else begin
                    n_w.bp  = sr_bp;
                    n_w.cur = sr_bp;
                end
            end
            CMD_SR_HDR: begin
                if (o_status.fit) begin
                    n_skip    = (r_w.asize >= W'(r_thresh)) ? '0 : r_w.bp;
                    n_w.csize = q_size;
                end
            end
            CMD_PL_SETUP: begin
                n_w.split = o_status.split;
                n_w.size  = o_status.split ? r_w.csize - r_w.asize : r_w.csize;
                n_w.alloc = !o_status.split;
            end
            CMD_PL_ADV: begin
                n_w.bp    = r_w.bp + r_w.size;
                n_w.size  = r_w.asize;
                n_w.alloc = 1'b1;
            end
            CMD_PL_DONE: begin
                n_w.res = r_w.bp;
                if (r_w.moving) begin
                    n_w.copy = copy_calc;
                end
            end
            CMD_GR_SETUP: begin
                n_w.bp    = r_heap_end;
                n_w.size  = grow;
                n_w.alloc = 1'b0;
            end
            CMD_WR_EPI: n_heap_end = r_w.bp + r_w.size;
            CMD_MG_NRD: n_w.pt = q;
            CMD_MG_CALC: begin
                n_w.bp    = r_w.pt[0] ? r_w.bp : r_w.bp - psize;
                n_w.size  = r_w.size + (r_w.pt[0] ? '0 : psize) + (q[0] ? '0 : q_size);
                n_w.csize = n_w.size;
                n_w.alloc = 1'b0;
            end
            CMD_FR_SETUP: begin
                n_w.bp    = r_w.p;
                n_w.size  = r_w.has;
                n_w.alloc = 1'b0;
            end
            CMD_LV_HDR: begin
                n_w.t   = q;
                n_w.has = q_size;
            end
            CMD_RA_TAIL: begin
                n_w.res    = r_w.p;
                n_w.moving = !o_status.ra_tail;
            end
            CMD_RA_SETUP: begin
                n_w.bp    = r_w.p;
                n_w.size  = r_w.asize;
                n_w.alloc = 1'b1;
            end
            CMD_FIN_OK: begin
                n_valid    = 1'b1;
                n_ok       = 1'b1;
                n_out_addr = r_w.res[ADDR_W-1:0];
                n_out_copy = r_w.copy[ADDR_W-1:0];
            end
            CMD_FIN_FAIL: begin
                n_valid    = 1'b1;
                n_ok       = 1'b0;
                n_out_addr = '0;
                n_out_copy = '0;
            end
            default: n_w = r_w;
        endcase
    end

    // status to the controller
    always_comb begin
        o_status.op        = r_w.op;
        o_status.p_zero    = (r_w.p == '0);
        o_status.req_zero  = (r_w.req == '0);
        o_status.moving    = r_w.moving;
        o_status.clr_last  = (r_clr == IW'(HEAP_WORDS - 1));
        o_status.srch_end  = (q_size == '0) || (q_size >= r_w.cur - W'(8));
        o_status.srch_skip = (sr_bp == r_skip);
        o_status.fit       = !q[0] && (r_w.asize <= q_size);
        o_status.split     = (r_w.csize >= r_w.asize) &&
                             ((r_w.csize - r_w.asize) >= W'(MIN_BLOCK));
        o_status.grow_fail = (grow > HEAP_BYTES) || (r_heap_end > HEAP_BYTES - grow);
        o_status.mg_both   = r_w.pt[0] && q[0];
        o_status.lv_bad0   = (r_w.p < W'(MIN_BLOCK)) || (r_w.p[2:0] != 3'b000) ||
                             (r_w.p >= r_heap_end);
        o_status.lv_bad1   = !q[0] || (q_size < W'(MIN_BLOCK)) ||
                             (q_size > r_heap_end - r_w.p);
        o_status.lv_ftr_ok = (q == r_w.t);
        o_status.ra_tail   = (q_size == '0);
        o_status.ra_fits   = (r_w.asize <= r_w.has);
        o_status.ra_room   = (r_w.asize <= HEAP_BYTES - r_w.p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_end <= W'(RESET_HEAP_END);
            r_skip     <= '0;
            r_chunk    <= CFG_W'(RESET_CHUNK);
            r_thresh   <= CFG_W'(RESET_THRESH);
            r_clr      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_heap_end <= n_heap_end;
            r_skip     <= n_skip;
            r_valid    <= n_valid;
            if (i_cmd == CMD_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_CHUNK:  r_chunk  <= i_cfg_data;
                    CFG_THRESH: r_thresh <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_rd_oob   <= !in_range;
        r_ok       <= n_ok;
        r_out_addr <= n_out_addr;
        r_out_copy <= n_out_copy;
    end

    assign o_valid          = r_valid;
    assign o_ok             = r_ok;
    assign o_result_address = r_out_addr;
    assign o_copy_bytes     = r_out_copy;
endmodule

[sv/bta_ctrl.sv]
// Controller: sequences the clearing pass, heap walk, liveness checks, tag writes and coalescing steps.
// Depends on bta_pkg; drives bta_dp with a command code and reads its status.
module bta_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bta_pkg::t_dp_status i_status,
    output bta_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    import bta_pkg::*;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    t_state ret_state;

    assign ret_state = (r_ret == RET_PLACE) ? ST_PL_SETUP : ST_FIN_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ret   <= RET_PLACE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = CMD_NOP;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd   = CMD_LATCH;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_status.op)
                    OP_ALLOC:   n_state = i_status.req_zero ? ST_FIN_FAIL : ST_SR_INIT;
                    OP_FREE:    n_state = ST_LV_CHK;
                    OP_REALLOC: begin
                        if (!i_status.p_zero)       n_state = ST_LV_CHK;
                        else if (i_status.req_zero) n_state = ST_FIN_FAIL;
                        else                        n_state = ST_SR_INIT;
                    end
                    default:    n_state = ST_FIN_FAIL;
                endcase
            end
            ST_SR_INIT: begin
                o_cmd   = CMD_SR_INIT;
                n_state = ST_SR_RD;
            end
            ST_SR_RD: begin
                o_cmd   = CMD_SR_RD;
                n_state = ST_SR_STEP;
            end
            ST_SR_STEP: begin
                o_cmd = CMD_SR_STEP;
                if (i_status.srch_end)       n_state = ST_GR_SETUP;
                else if (i_status.srch_skip) n_state = ST_SR_RD;
                else                         n_state = ST_SR_HRD;
            end
            ST_SR_HRD: begin
                o_cmd   = CMD_SR_HRD;
                n_state = ST_SR_HDR;
            end
            ST_SR_HDR: begin
                o_cmd   = CMD_SR_HDR;
                n_state = i_status.fit ? ST_PL_SETUP : ST_SR_RD;
            end
            ST_GR_SETUP: begin
                o_cmd   = CMD_GR_SETUP;
                n_state = i_status.grow_fail ? ST_FIN_FAIL : ST_GR_HDR;
            end
            ST_GR_HDR: begin
                o_cmd   = CMD_WR_HDR;
                n_state = ST_GR_FTR;
            end
            ST_GR_FTR: begin
                o_cmd   = CMD_WR_FTR;
                n_state = ST_GR_EPI;
            end
            ST_GR_EPI: begin
                o_cmd   = CMD_WR_EPI;
                n_ret   = RET_PLACE;
                n_state = ST_MG_PRD;
            end
            ST_MG_PRD: begin
                o_cmd   = CMD_MG_PRD;
                n_state = ST_MG_NRD;
            end
            ST_MG_NRD: begin
                o_cmd   = CMD_MG_NRD;
                n_state = ST_MG_CALC;
            end
            ST_MG_CALC: begin
                o_cmd   = CMD_MG_CALC;
                n_state = i_status.mg_both ? ret_state : ST_MG_HDR;
            end
            ST_MG_HDR: begin
                o_cmd   = CMD_WR_HDR;
                n_state = ST_MG_FTR;
            end
            ST_MG_FTR: begin
                o_cmd   = CMD_WR_FTR;
                n_state = ret_state;
            end
            ST_PL_SETUP: begin
                o_cmd   = CMD_PL_SETUP;
                n_state = ST_PL_HDR1;
            end
            ST_PL_HDR1: begin
                o_cmd   = CMD_WR_HDR;
                n_state = ST_PL_FTR1;
            end
            ST_PL_FTR1: begin
                o_cmd   = CMD_WR_FTR;
                n_state = i_status.split ? ST_PL_ADV : ST_PL_DONE;
            end
            ST_PL_ADV: begin
                o_cmd   = CMD_PL_ADV;
                n_state = ST_PL_HDR2;
            end
            ST_PL_HDR2: begin
                o_cmd   = CMD_WR_HDR;
                n_state = ST_PL_FTR2;
            end
            ST_PL_FTR2: begin
                o_cmd   = CMD_WR_FTR;
                n_state = ST_PL_DONE;
            end
            ST_PL_DONE: begin
                o_cmd   = CMD_PL_DONE;
                n_state = i_status.moving ? ST_FR_SETUP : ST_FIN_OK;
            end
            ST_FR_SETUP: begin
                o_cmd   = CMD_FR_SETUP;
                n_state = ST_FR_HDR;
            end
            ST_FR_HDR: begin
                o_cmd   = CMD_WR_HDR;
                n_state = ST_FR_FTR;
            end
            ST_FR_FTR: begin
                o_cmd   = CMD_WR_FTR;
                n_ret   = RET_FIN;
                n_state = ST_MG_PRD;
            end
            ST_LV_CHK: begin
                o_cmd   = CMD_LV_CHK;
                n_state = i_status.lv_bad0 ? ST_FIN_FAIL : ST_LV_HDR;
            end
            ST_LV_HDR: begin
                o_cmd   = CMD_LV_HDR;
                n_state = i_status.lv_bad1 ? ST_FIN_FAIL : ST_LV_FTR;
            end
            ST_LV_FTR: begin
                if (!i_status.lv_ftr_ok)        n_state = ST_FIN_FAIL;
                else if (i_status.op == OP_FREE) n_state = ST_FR_SETUP;
                else if (i_status.req_zero)     n_state = ST_FIN_FAIL;
                else                            n_state = ST_RA_NRD;
            end
            ST_RA_NRD: begin
                o_cmd   = CMD_RA_NRD;
                n_state = ST_RA_TAIL;
            end
            ST_RA_TAIL: begin
                o_cmd = CMD_RA_TAIL;
                if (!i_status.ra_tail)     n_state = ST_SR_INIT;
                else if (i_status.ra_fits) n_state = ST_FIN_OK;
                else if (i_status.ra_room) n_state = ST_RA_SETUP;
                else                       n_state = ST_FIN_FAIL;
            end
            ST_RA_SETUP: begin
                o_cmd   = CMD_RA_SETUP;
                n_state = ST_RA_HDR;
            end
            ST_RA_HDR: begin
                o_cmd   = CMD_WR_HDR;
                n_state = ST_RA_FTR;
            end
            ST_RA_FTR: begin
                o_cmd   = CMD_WR_FTR;
                n_state = ST_RA_EPI;
            end
            ST_RA_EPI: begin
                o_cmd   = CMD_WR_EPI;
                n_state = ST_FIN_OK;
            end
            ST_FIN_OK: begin
                o_cmd   = CMD_FIN_OK;
                n_state = ST_IDLE;
            end
            ST_FIN_FAIL: begin
                o_cmd   = CMD_FIN_FAIL;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
